### hdl/dela_pkg.sv
// Shared types and constants of the double-ended linear allocator.
package dela_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned AlignW = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned SumW = DataW + 2;

  localparam logic [DataW-1:0] ResetBase = 32'd0;
  localparam logic [DataW-1:0] ResetRegionSize = 32'd65536;
  localparam logic [DataW-1:0] CountMax = 32'hFFFF_FFFF;

  // Request kinds.
  localparam logic ActAlloc = 1'b0;
  localparam logic ActClear = 1'b1;

  // End select codes.
  localparam logic EndBottom = 1'b0;
  localparam logic EndTop = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgBase = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRegionSize = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgEndSelect = 2'd2;

  typedef struct packed {
    logic action;
    logic [DataW-1:0] request_size;
    logic [AlignW-1:0] alignment_log2;
  } req_t;

  typedef struct packed {
    logic granted;
    logic [DataW-1:0] block_address;
    logic [DataW-1:0] used_bytes;
    logic [DataW-1:0] allocation_count;
  } rsp_t;

  typedef enum logic [1:0] {
    StIdle,
    StAlign,
    StCommit
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic prepare;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

### hdl/dela_ctrl.sv
// Request sequencer of the allocator: accept, align, commit.
module dela_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  dela_pkg::sts_t sts_i,
  output dela_pkg::cmd_t cmd_o
);

  dela_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dela_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    req_ready_o = 1'b0;
    cmd_o = '0;
    unique case (state_q)
      dela_pkg::StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = dela_pkg::StAlign;
        end
      end
      dela_pkg::StAlign: begin
        cmd_o.prepare = 1'b1;
        state_d = dela_pkg::StCommit;
      end
      dela_pkg::StCommit: begin
        // hold until the result register can take the new result
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = dela_pkg::StIdle;
        end
      end
      default: begin
        state_d = dela_pkg::StIdle;
      end
    endcase
  end

endmodule

### hdl/dela_datapath.sv
// Allocator datapath: configuration, pointers, counters and result register.
module dela_datapath #(
  parameter int unsigned ADDR_WIDTH = 32,
  parameter int unsigned MAX_ALIGN_LOG2 = 7
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dela_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dela_pkg::DataW-1:0]     cfg_data_i,
  input  dela_pkg::req_t                 req_i,
  input  dela_pkg::cmd_t                 cmd_i,
  output dela_pkg::sts_t                 sts_o,
  output logic                           rsp_valid_o,
  input  logic                           rsp_ready_i,
  output dela_pkg::rsp_t                 rsp_o
);

  localparam int unsigned PadW = (MAX_ALIGN_LOG2 > 0) ? MAX_ALIGN_LOG2 : 1;
  localparam int unsigned DW = dela_pkg::DataW;
  localparam int unsigned SW = dela_pkg::SumW;

  // configuration
  logic [DW-1:0] base_q;
  logic [DW-1:0] region_q;
  logic end_sel_q;

  // allocator state
  logic [ADDR_WIDTH-1:0] bottom_q;
  logic [ADDR_WIDTH-1:0] top_q;
  logic [DW-1:0] used_q;
  logic [DW-1:0] count_q;

  // per-request working registers
  dela_pkg::req_t req_q;
  logic [SW-1:0] sum_q;
  logic [ADDR_WIDTH-1:0] addr_q;
  logic [ADDR_WIDTH-1:0] next_ptr_q;

  logic rsp_valid_q;
  dela_pkg::rsp_t rsp_q;

  // alignment and padding
  logic [dela_pkg::AlignW-1:0] lg_sat;
  logic [PadW-1:0] align_mask;
  logic [PadW-1:0] pad;
  logic [ADDR_WIDTH-1:0] pad_ext;
  logic [ADDR_WIDTH-1:0] size_ext;
  logic fits;
  logic [ADDR_WIDTH-1:0] rewind_bottom;
  logic [ADDR_WIDTH-1:0] rewind_top;

  always_comb begin
    if (req_q.alignment_log2 > dela_pkg::AlignW'(MAX_ALIGN_LOG2)) begin
      lg_sat = dela_pkg::AlignW'(MAX_ALIGN_LOG2);
    end else begin
      lg_sat = req_q.alignment_log2;
    end
    if (MAX_ALIGN_LOG2 == 0) begin
      align_mask = '0;
    end else begin
      align_mask = ~({PadW{1'b1}} << lg_sat);
    end
    if (end_sel_q == dela_pkg::EndTop) begin
      pad = top_q[PadW-1:0] & align_mask;
    end else begin
      pad = (~bottom_q[PadW-1:0] + PadW'(1)) & align_mask;
    end
    pad_ext = ADDR_WIDTH'(pad);
    size_ext = ADDR_WIDTH'(req_q.request_size);
    fits = (req_q.request_size != '0) && (sum_q <= SW'(region_q));
    rewind_bottom = ADDR_WIDTH'(base_q);
    rewind_top = ADDR_WIDTH'(base_q) + ADDR_WIDTH'(region_q) - ADDR_WIDTH'(1);
  end

  assign sts_o.out_free = !rsp_valid_q || rsp_ready_i;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o = rsp_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= dela_pkg::ResetBase;
      region_q <= dela_pkg::ResetRegionSize;
      end_sel_q <= dela_pkg::EndBottom;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dela_pkg::CfgBase:       base_q <= cfg_data_i;
        dela_pkg::CfgRegionSize: region_q <= cfg_data_i;
        dela_pkg::CfgEndSelect:  end_sel_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.prepare) begin
      sum_q <= SW'(used_q) + SW'(pad) + SW'(req_q.request_size);
      if (end_sel_q == dela_pkg::EndTop) begin
        addr_q <= top_q - pad_ext - size_ext;
        next_ptr_q <= top_q - pad_ext - size_ext;
      end else begin
        addr_q <= bottom_q + pad_ext;
        next_ptr_q <= bottom_q + pad_ext + size_ext;
      end
    end
  end

  // allocator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bottom_q <= ADDR_WIDTH'(dela_pkg::ResetBase);
      top_q <= ADDR_WIDTH'(dela_pkg::ResetBase) + ADDR_WIDTH'(dela_pkg::ResetRegionSize)
               - ADDR_WIDTH'(1);
      used_q <= '0;
      count_q <= '0;
    end else if (cmd_i.commit) begin
      if (req_q.action == dela_pkg::ActClear) begin
        bottom_q <= rewind_bottom;
        top_q <= rewind_top;
        used_q <= '0;
        count_q <= '0;
      end else if (fits) begin
        if (end_sel_q == dela_pkg::EndTop) begin
          top_q <= next_ptr_q;
        end else begin
          bottom_q <= next_ptr_q;
        end
        used_q <= sum_q[DW-1:0];
        if (count_q != dela_pkg::CountMax) begin
          count_q <= count_q + DW'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (req_q.action == dela_pkg::ActClear) begin
        rsp_q <= '{granted: 1'b1, block_address: '0, used_bytes: '0,
                   allocation_count: '0};
      end else if (fits) begin
        rsp_q.granted <= 1'b1;
        rsp_q.block_address <= DW'(addr_q);
        rsp_q.used_bytes <= sum_q[DW-1:0];
        rsp_q.allocation_count <= (count_q != dela_pkg::CountMax) ? count_q + DW'(1)
                                                                  : count_q;
      end else begin
        rsp_q <= '{granted: 1'b0, block_address: '0, used_bytes: used_q,
                   allocation_count: count_q};
      end
    end
  end

endmodule

### hdl/double_ended_linear_allocator_core.sv
// Top level of the double-ended linear allocator.
//
//   channel   direction  handshake                  payload
//   request   in         req_valid_i / req_ready_o  req_i  (action, size, alignment)
//   result    out        rsp_valid_o / rsp_ready_i  rsp_o  (grant, address, used, count)
//   config    in         cfg_we_i                   cfg_index_i, cfg_data_i
//
// A request passes through three steps: accept, align (padding, candidate address and
// the used-byte sum are registered), commit (fit check and state update).
// Commit waits while the result register holds a result that is not yet taken;
// a new request is accepted while a finished result waits.
// Reset clears the pointers to the default region and both counts; no clearing pass.
// Size and end select act at once; base and size move the pointers at the next clear.
module double_ended_linear_allocator_core #(
  parameter int unsigned ADDR_WIDTH = 32,
  parameter int unsigned MAX_ALIGN_LOG2 = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dela_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dela_pkg::DataW-1:0]   cfg_data_i,
  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  dela_pkg::req_t               req_i,
  output logic                         rsp_valid_o,
  input  logic                         rsp_ready_i,
  output dela_pkg::rsp_t               rsp_o
);

  dela_pkg::cmd_t cmd;
  dela_pkg::sts_t sts;

  // sequence each request through capture, prepare and commit
  dela_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // hold configuration, both end pointers, counts and the result register
  dela_datapath #(
    .ADDR_WIDTH     (ADDR_WIDTH),
    .MAX_ALIGN_LOG2 (MAX_ALIGN_LOG2)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

endmodule

### hdl/dela_checker.sv
// Port-level checks of the allocator, bound to the top level.
module dela_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_o,
  input logic           rsp_valid_o,
  input logic           rsp_ready_i,
  input dela_pkg::rsp_t rsp_o
);

  // a stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> $stable(rsp_o))
    else $error("result changed while stalled");

  // one request at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o)
    else $error("request accepted while another is in flight");

  // a grant with zero count can only be a clear result
  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.granted && (rsp_o.allocation_count == '0)
      |-> (rsp_o.used_bytes == '0) && (rsp_o.block_address == '0))
    else $error("grant with zero count carries nonzero fields");

endmodule

bind double_ended_linear_allocator_core dela_checker u_dela_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_valid_i),
  .req_ready_o (req_ready_o),
  .rsp_valid_o (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i),
  .rsp_o       (rsp_o)
);

### tb/alloc_checker.sv
`timescale 1ns / 1ps
// Allocator checker: tracks region state, predicts each result and compares it.
module alloc_checker #(
  parameter int unsigned MaxAlignLog2 = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dela_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dela_pkg::DataW-1:0]   cfg_data_i,
  input  logic                         req_valid_i,
  input  logic                         req_ready_i,
  input  dela_pkg::req_t               req_i,
  input  logic                         rsp_valid_i,
  input  logic                         rsp_ready_i,
  input  dela_pkg::rsp_t               rsp_i,
  output int unsigned                  outstanding_o,
  output int unsigned                  errors_o
);

  logic [dela_pkg::DataW-1:0] base_addr;
  logic [dela_pkg::DataW-1:0] region_bytes;
  logic                       end_sel;

  logic [dela_pkg::DataW-1:0] bottom_ptr;
  logic [dela_pkg::DataW-1:0] top_ptr;
  logic [dela_pkg::DataW-1:0] used_total;
  logic [dela_pkg::DataW-1:0] grants;

  dela_pkg::rsp_t owed_results[$];
  int unsigned    mismatches;

  task automatic rewind_region();
    bottom_ptr = base_addr;
    top_ptr    = base_addr + region_bytes - dela_pkg::DataW'(1);
    used_total = '0;
    grants     = '0;
  endtask

  // Apply one request to the tracked state and return its result.
  task automatic carve_block(input dela_pkg::req_t r, output dela_pkg::rsp_t res);
    int unsigned                lg;
    logic [dela_pkg::DataW-1:0] align_mask;
    logic [dela_pkg::DataW-1:0] pad;
    logic [dela_pkg::DataW-1:0] start;
    logic [dela_pkg::SumW-1:0]  need;
    res = '0;
    if (r.action == dela_pkg::ActClear) begin
      rewind_region();
      res.granted = 1'b1;
    end else begin
      lg = 32'(r.alignment_log2);
      if (lg > MaxAlignLog2) lg = MaxAlignLog2;
      align_mask = (dela_pkg::DataW'(1) << lg) - dela_pkg::DataW'(1);
      if (end_sel == dela_pkg::EndTop) pad = top_ptr & align_mask;
      else pad = (dela_pkg::DataW'(0) - bottom_ptr) & align_mask;
      need = dela_pkg::SumW'(used_total) + dela_pkg::SumW'(pad)
             + dela_pkg::SumW'(r.request_size);
      if (r.request_size != '0 && need <= dela_pkg::SumW'(region_bytes)) begin
        if (end_sel == dela_pkg::EndTop) begin
          start   = top_ptr - pad - r.request_size;
          top_ptr = start;
        end else begin
          start      = bottom_ptr + pad;
          bottom_ptr = start + r.request_size;
        end
        used_total = used_total + pad + r.request_size;
        if (grants != dela_pkg::CountMax) grants = grants + dela_pkg::DataW'(1);
        res.granted       = 1'b1;
        res.block_address = start;
      end
    end
    res.used_bytes       = used_total;
    res.allocation_count = grants;
  endtask

  function automatic int unsigned compare_result(dela_pkg::rsp_t want, dela_pkg::rsp_t got);
    int unsigned bad;
    bad = 0;
    if (got.granted !== want.granted) begin
      $error("granted: expected %0d, got %0d", want.granted, got.granted);
      bad++;
    end
    if (got.block_address !== want.block_address) begin
      $error("block_address: expected %08h, got %08h", want.block_address, got.block_address);
      bad++;
    end
    if (got.used_bytes !== want.used_bytes) begin
      $error("used_bytes: expected %08h, got %08h", want.used_bytes, got.used_bytes);
      bad++;
    end
    if (got.allocation_count !== want.allocation_count) begin
      $error("allocation_count: expected %0d, got %0d",
             want.allocation_count, got.allocation_count);
      bad++;
    end
    return bad;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    dela_pkg::rsp_t want;
    if (!rst_ni) begin
      base_addr    = dela_pkg::ResetBase;
      region_bytes = dela_pkg::ResetRegionSize;
      end_sel      = dela_pkg::EndBottom;
      rewind_region();
      owed_results.delete();
      mismatches = 0;
      outstanding_o <= 0;
      errors_o      <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          dela_pkg::CfgBase:       base_addr = cfg_data_i;
          dela_pkg::CfgRegionSize: region_bytes = cfg_data_i;
          dela_pkg::CfgEndSelect:  end_sel = cfg_data_i[0];
          default: ;
        endcase
      end
      // Retire the oldest result before queuing a new one.
      if (rsp_valid_i && rsp_ready_i) begin
        if (owed_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          mismatches += compare_result(want, rsp_i);
        end
      end
      if (req_valid_i && req_ready_i) begin
        carve_block(req_i, want);
        owed_results.push_back(want);
      end
      outstanding_o <= owed_results.size();
      errors_o      <= mismatches;
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench top: drives requests, register writes and result stalls, gives the verdict.
module tb;

  // Wait on after the last result before touching the registers or ending the run.
  localparam int unsigned SettleCycles = 6;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [dela_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [dela_pkg::DataW-1:0]   cfg_data = '0;
  logic                         req_valid = 1'b0;
  dela_pkg::req_t               req_item = '0;
  logic                         req_ready;
  logic                         rsp_valid;
  logic                         rsp_ready = 1'b0;
  dela_pkg::rsp_t               rsp;

  // Idle control shared by the sender and the result sink.
  logic        steady = 1'b0;
  int unsigned hold_token = 0;

  int unsigned outstanding;
  int unsigned errors;
  int unsigned sent = 0;
  int unsigned settings = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  double_ended_linear_allocator_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .req_valid_i(req_valid),
    .req_ready_o(req_ready),
    .req_i      (req_item),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp)
  );

  alloc_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .req_valid_i  (req_valid),
    .req_ready_i  (req_ready),
    .req_i        (req_item),
    .rsp_valid_i  (rsp_valid),
    .rsp_ready_i  (rsp_ready),
    .rsp_i        (rsp),
    .outstanding_o(outstanding),
    .errors_o     (errors)
  );

  // Stop a hung run; a correct run needs only a small part of this.
  initial begin : watchdog
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result sink: drop ready at random, never in a steady stretch, and hold
  // it low for a long stretch whenever the stimulus asks for a hold-off.
  initial begin : result_sink
    int unsigned seen_holds;
    int unsigned stall_left;
    seen_holds = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_token != seen_holds) begin
        seen_holds = hold_token;
        stall_left = 60;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= steady || ($urandom_range(99) >= 38);
      end
    end
  end

  function automatic dela_pkg::req_t alloc_req(logic [dela_pkg::DataW-1:0] size,
                                               int unsigned lg);
    dela_pkg::req_t r;
    r.action         = dela_pkg::ActAlloc;
    r.request_size   = size;
    r.alignment_log2 = dela_pkg::AlignW'(lg);
    return r;
  endfunction

  function automatic dela_pkg::req_t clear_req();
    dela_pkg::req_t r;
    r.action         = dela_pkg::ActClear;
    r.request_size   = $urandom();
    r.alignment_log2 = dela_pkg::AlignW'($urandom_range(7));
    return r;
  endfunction

  // Mostly small allocations so regions fill up and get refused; some
  // clears, zero sizes, region-sized and fully random sizes mixed in.
  function automatic dela_pkg::req_t random_request(logic [dela_pkg::DataW-1:0] span);
    int unsigned    pick;
    dela_pkg::req_t r;
    pick = $urandom_range(99);
    r = alloc_req($urandom_range(48, 1), $urandom_range(7));
    if (pick < 4) r = clear_req();
    else if (pick < 10) r.request_size = '0;
    else if (pick < 18) r.request_size = $urandom();
    else if (pick < 30) r.request_size = $urandom_range(span, 1);
    return r;
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic offer(input dela_pkg::req_t r);
    while (!steady && $urandom_range(99) < 38) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= r;
    do @(posedge clk); while (!req_ready);
    sent++;
  endtask

  // Drop valid and wait until every result has come back.
  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write all three registers on consecutive cycles; call only when idle.
  task automatic program_region(input logic [dela_pkg::DataW-1:0] base,
                                input logic [dela_pkg::DataW-1:0] span,
                                input logic sel);
    cfg_we    <= 1'b1;
    cfg_index <= dela_pkg::CfgBase;
    cfg_data  <= base;
    @(posedge clk);
    cfg_index <= dela_pkg::CfgRegionSize;
    cfg_data  <= span;
    @(posedge clk);
    cfg_index <= dela_pkg::CfgEndSelect;
    cfg_data  <= dela_pkg::DataW'(sel);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic run_phase(input logic [dela_pkg::DataW-1:0] base,
                           input logic [dela_pkg::DataW-1:0] span,
                           input logic sel, input bit start_clear, input int unsigned count,
                           input bit quiet, input bit holdoff);
    settle();
    program_region(base, span, sel);
    steady <= quiet;
    if (start_clear) offer(clear_req());
    for (int unsigned i = 0; i < count; i++) begin
      // Stall results for a long stretch while requests keep coming.
      if (holdoff && i == count / 4) hold_token <= hold_token + 1;
      offer(random_request(span));
    end
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset region, bottom end: zero size, all alignments, an all-ones size.
    offer(alloc_req(32'd0, 0));
    offer(alloc_req(32'd1, 0));
    offer(alloc_req(32'd3, 2));
    offer(alloc_req(32'hFFFF_FFFF, 7));
    offer(alloc_req(32'd16, 7));
    offer(alloc_req(32'd1, 1));
    offer(alloc_req(32'd1, 3));
    offer(alloc_req(32'd1, 5));
    offer(alloc_req(32'd1, 6));
    offer(alloc_req(32'h0001_0000, 4));

    // Switch to the top end with a new region but no clear: the top pointer
    // stays where reset put it, the fit check already uses the new size.
    settle();
    program_region(32'h0000_1000, 32'd256, dela_pkg::EndTop);
    offer(alloc_req(32'd8, 3));
    offer(clear_req());
    offer(alloc_req(32'd16, 4));
    // Exact fill of the region, then one byte more is refused.
    offer(alloc_req(32'd225, 0));
    offer(alloc_req(32'd1, 0));

    // Largest region near the top of the address space: alignment wraps.
    settle();
    program_region(32'hFFFF_FFC0, 32'hFFFF_FFFF, dela_pkg::EndBottom);
    offer(clear_req());
    offer(alloc_req(32'h80, 7));
    offer(alloc_req(32'hFFFF_FFFF, 0));

    // Empty region: every allocate refused, top pointer one below base.
    settle();
    program_region(32'hFFFF_FFFF, 32'd0, dela_pkg::EndTop);
    offer(clear_req());
    offer(alloc_req(32'd1, 0));

    // One-byte region at address zero, top end: the block wraps below zero.
    settle();
    program_region(32'd0, 32'd1, dela_pkg::EndTop);
    offer(clear_req());
    offer(alloc_req(32'd1, 0));
    offer(alloc_req(32'd1, 0));

    run_phase(32'd0, 32'd4096, dela_pkg::EndBottom, 1'b1, 110, 1'b0, 1'b1);
    run_phase(32'd0, 32'd4096, dela_pkg::EndTop, 1'b0, 70, 1'b0, 1'b0);
    run_phase($urandom(), 32'hFFFF_FFFF, dela_pkg::EndTop, 1'b1, 100, 1'b1, 1'b0);
    run_phase($urandom(), $urandom_range(1024, 64), dela_pkg::EndBottom, 1'b1, 50, 1'b0,
              1'b0);
    run_phase($urandom(), $urandom_range(1024, 64), dela_pkg::EndTop, 1'b0, 50, 1'b0, 1'b1);
    run_phase(32'hFFFF_FF00, 32'd512, dela_pkg::EndBottom, 1'b1, 40, 1'b0, 1'b0);
    run_phase(32'hFFFF_FF00, 32'd512, dela_pkg::EndTop, 1'b0, 40, 1'b0, 1'b0);
    run_phase($urandom(), 32'd1, dela_pkg::EndBottom, 1'b1, 20, 1'b0, 1'b0);
    settle();

    $display("Ran %0d requests over %0d register settings, allocating from both ends,",
             sent, settings);
    $display("with clears, refusals, exact fills, address wrap and a long result stall.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
